// File: hw/rtl/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared widths, character codes, register map and the classified-item type
// for the text to integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

  localparam int unsigned ChW        = 8;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned RadixW     = 5;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [RadixW-1:0]   RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0]   RadixMin   = RadixW'(2);
  localparam logic [RadixW-1:0]   RadixMax   = RadixW'(16);
  localparam logic [ApbAddrW-1:0] RadixAddr  = '0;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0D;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChUpA   = 8'h41;
  localparam logic [ChW-1:0] ChUpF   = 8'h46;
  localparam logic [ChW-1:0] ChLoA   = 8'h61;
  localparam logic [ChW-1:0] ChLoF   = 8'h66;
  localparam logic [ChW-1:0] LetterBias = 8'd10;

  typedef enum logic [2:0] {
    KindSpace,
    KindPlus,
    KindMinus,
    KindDigit,
    KindOther,
    KindEnd
  } tti_kind_e;

  typedef struct packed {
    tti_kind_e         kind;
    logic [DigitW-1:0] digit;
    logic              radix_ok;
  } tti_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/tti_ch_if.sv
// ----------------------------------------------------------------------------
// tti_ch_if
// Valid/ready channel carrying one input character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tti_ch_if;
  import tti_pkg::*;

  logic           valid;
  logic           ready;
  logic [ChW-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tti_value_if.sv
// ----------------------------------------------------------------------------
// tti_value_if
// Valid/ready channel carrying one parsed signed value per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tti_value_if;
  import tti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tti_front.sv
// ----------------------------------------------------------------------------
// tti_front
// Accepts characters and classifies each one against the current radix.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_front (
  input  wire logic [tti_pkg::RadixW-1:0] radix_i,
  tti_ch_if.sink                          ch_if,
  input  wire logic                       q_full_i,
  output logic                            push_o,
  output tti_pkg::tti_item_t              item_o
);
  import tti_pkg::*;

  logic [ChW-1:0]    ch;
  logic [ChW-1:0]    raw;
  logic              is_digit;
  logic [DigitW-1:0] digit;

  assign ch          = ch_if.ch;
  assign ch_if.ready = !q_full_i;
  assign push_o      = ch_if.valid && !q_full_i;

  always_comb begin
    raw      = '0;
    is_digit = 1'b0;
    if (ch >= ChZero && ch <= ChNine) begin
      raw      = ch - ChZero;
      is_digit = 1'b1;
    end else if (ch >= ChUpA && ch <= ChUpF) begin
      raw      = ch - ChUpA + LetterBias;
      is_digit = 1'b1;
    end else if (ch >= ChLoA && ch <= ChLoF) begin
      raw      = ch - ChLoA + LetterBias;
      is_digit = 1'b1;
    end
    digit = raw[DigitW-1:0];
  end

  always_comb begin
    item_o.digit    = digit;
    item_o.radix_ok = (radix_i >= RadixMin) && (radix_i <= RadixMax);
    if (ch == ChNul) begin
      item_o.kind = KindEnd;
    end else if ((ch >= ChTab && ch <= ChCr) || ch == ChSpace) begin
      item_o.kind = KindSpace;
    end else if (ch == ChPlus) begin
      item_o.kind = KindPlus;
    end else if (ch == ChMinus) begin
      item_o.kind = KindMinus;
    end else if (is_digit && (RadixW'(digit) < radix_i)) begin
      item_o.kind = KindDigit;
    end else begin
      item_o.kind = KindOther;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tti_queue.sv
// ----------------------------------------------------------------------------
// tti_queue
// Small FIFO of classified characters between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_queue #(
  parameter int unsigned Depth = tti_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire tti_pkg::tti_item_t item_i,
  output logic                    full_o,
  output logic                    valid_o,
  output tti_pkg::tti_item_t      item_o,
  input  wire logic               pop_i
);
  import tti_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tti_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tti_back.sv
// ----------------------------------------------------------------------------
// tti_back
// Runs the parse state machine on classified characters, gathers digits and
// holds the finished value in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [tti_pkg::RadixW-1:0] radix_i,
  input  wire logic                       q_valid_i,
  input  wire tti_pkg::tti_item_t         item_i,
  output logic                            pop_o,
  tti_value_if.source                     value_if
);
  import tti_pkg::*;

  typedef enum logic [1:0] {
    PhLead,
    PhGather,
    PhStop
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic [ValueW-1:0]        accum_q, accum_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic [ValueW-1:0]        mac;

  // The output register can take a new value when empty or being drained.
  assign pop_o = q_valid_i &&
                 ((item_i.kind != KindEnd) || !out_valid_q || value_if.ready);

  assign mac = (accum_q * ValueW'(radix_i)) + ValueW'(item_i.digit);

  assign value_if.valid = out_valid_q;
  assign value_if.value = value_q;

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    accum_d     = accum_q;
    out_valid_d = out_valid_q && !value_if.ready;
    value_d     = value_q;
    if (pop_o) begin
      if (item_i.kind == KindEnd) begin
        out_valid_d = 1'b1;
        if (!item_i.radix_ok) begin
          value_d = '0;
        end else if (neg_q) begin
          value_d = signed'(ValueW'(0) - accum_q);
        end else begin
          value_d = signed'(accum_q);
        end
        phase_d = PhLead;
        neg_d   = 1'b0;
        accum_d = '0;
      end else begin
        case (phase_q)
          PhLead: begin
            case (item_i.kind)
              KindSpace: phase_d = PhLead;
              KindPlus:  phase_d = PhGather;
              KindMinus: begin
                neg_d   = 1'b1;
                phase_d = PhGather;
              end
              KindDigit: begin
                accum_d = ValueW'(item_i.digit);
                phase_d = PhGather;
              end
              default:   phase_d = PhStop;
            endcase
          end
          PhGather: begin
            if (item_i.kind == KindDigit) begin
              accum_d = mac;
            end else begin
              phase_d = PhStop;
            end
          end
          default: phase_d = PhStop;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      neg_q       <= 1'b0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      accum_q     <= accum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_to_int_any_base_unit.sv
// ----------------------------------------------------------------------------
// text_to_int_any_base_unit
// Streaming string to signed integer parser for bases 2 to 16.
// ----------------------------------------------------------------------------
// Result path: the zero byte is written into the queue, and is then evaluated
//   into the output register once that register is empty or being drained.
// Throughput: one character per cycle while the queue is not full; the back
//   part does one 32x5 bit multiply-add per digit, and the queue lets the
//   input keep flowing while a result waits at the output.
// Reset: asynchronous, active low; the parser returns to skipping leading
//   white space, the queue and output empty, and the radix reads 10.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_int_any_base_unit #(
  parameter int unsigned QueueDepth = tti_pkg::QueueDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration port. The only register is the radix at address 0.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tti_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [tti_pkg::ApbDataW-1:0] pwdata,
  output logic      [tti_pkg::ApbDataW-1:0] prdata,
  output logic                              pready,
  // Character stream in and value stream out.
  tti_ch_if.sink                            ch_if,
  tti_value_if.source                       value_if
);
  import tti_pkg::*;

  logic [RadixW-1:0] radix_q;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_valid;
  tti_item_t         front_item;
  tti_item_t         back_item;

  // The radix register. Software must write it only while the parser is idle;
  // this is not enforced. Both parts read it directly, not staged with items.
  assign pready = 1'b1;
  assign prdata = (paddr == RadixAddr) ? ApbDataW'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (psel && penable && pwrite && (paddr == RadixAddr)) begin
      radix_q <= pwdata[RadixW-1:0];
    end
  end

  // The front part classifies each character as it is transferred in:
  // white space, sign, digit below the radix, other, or end of string.
  tti_front u_front (
    .radix_i  (radix_q),
    .ch_if    (ch_if),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (front_item)
  );

  // The queue decouples classification from evaluation, so that a stalled
  // output does not immediately stall the input.
  tti_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (back_item),
    .pop_i   (pop)
  );

  // The back part owns the parse phase, the sign and the accumulator, and emits
  // the wrapped signed value (zero for a bad radix) when the end of the string arrives.
  tti_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .radix_i   (radix_q),
    .q_valid_i (q_valid),
    .item_i    (back_item),
    .pop_o     (pop),
    .value_if  (value_if)
  );

endmodule

`default_nettype wire
